// File: src/canonical_huffman_bit_decoder_unit_macros.svh
// assertion helpers for the canonical huffman bit decoder
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_UNIT_MACROS_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_UNIT_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define CHBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk while out of reset
`define CHBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/chbd_pkg.sv
`timescale 1ns / 1ps
package chbd_pkg;

	localparam int MAX_LENGTH_DEF    = 15;
	localparam int ALPHABET_SIZE_DEF = 256;

	// operation codes
	localparam logic [1:0] OP_LOAD_COUNT  = 2'd0;
	localparam logic [1:0] OP_LOAD_SYMBOL = 2'd1;
	localparam logic [1:0] OP_DECODE      = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic       code_bit;
		logic [3:0] length_slot;
		logic [8:0] len_count;
		logic [7:0] symbol_slot;
		logic [7:0] symbol_value;
	} req_item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       invalid_code;
	} rsp_item_t;

endpackage

// File: src/canonical_huffman_bit_decoder_unit.sv
`timescale 1ns / 1ps
// canonical huffman bit decoder
// usage:
//   req channel (req_valid / req_ready / req) carries one item per handshake:
//   load a code count for a length, load one entry of the length-sorted symbol
//   table, or decode one payload bit. loads restart the running code.
//   rsp channel (rsp_valid / rsp_ready / rsp) carries a decoded symbol, or
//   invalid_code = 1 (symbol 0) when no code matched within MAX_LENGTH bits.
//   only the bit that completes a code (or fails) yields an item on rsp.
// timing:
//   an accepted item is held in the input register, is resolved there
//   by a single compare / subtract / add and a symbol-table read, and its
//   result then goes to the output register. throughput is one item per
//   cycle but for a result held by rsp; the per-bit state loop closes there.
// reset:
//   arst_n clears the count table, the decode state and both valid flags;
//   the symbol table is not cleared and must be loaded before use.
// stall:
//   while rsp is held, the input register still takes items and drains any
//   that give no result; an item that gives a result waits in the input
//   register, and req_ready drops only then.
`include "canonical_huffman_bit_decoder_unit_macros.svh"
module canonical_huffman_bit_decoder_unit
	import chbd_pkg::*;
#(
	parameter int MAX_LENGTH    = MAX_LENGTH_DEF,
	parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	// widths
	localparam int CNT_W = 9;                                    // code count
	localparam int BT_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int LN_W  = ((BT_W > 4) ? BT_W : 4) + 1;          // length compare
	localparam int GC_W  = MAX_LENGTH + 1;                       // group first code
	localparam int DW    = (GC_W > CNT_W + 1) ? GC_W : CNT_W + 1;
	localparam int FW    = DW + 1;                               // first-code sum
	localparam int AW    = $clog2(ALPHABET_SIZE);                // symbol address
	localparam int IW    = $clog2(ALPHABET_SIZE + 1);            // group first index
	localparam int SW    = ((IW > CNT_W) ? IW : CNT_W) + 1;      // index sums
	localparam int SL_W  = ((AW > 8) ? AW : 8) + 1;              // slot compare

	localparam logic [FW:0]   FC_CAP = {{(FW - MAX_LENGTH){1'b0}}, {GC_W{1'b1}}};
	localparam logic [SW-1:0] AS_SW  = SW'(ALPHABET_SIZE);
	localparam logic [LN_W-1:0] ML_LN = LN_W'(MAX_LENGTH);

	// input register
	logic      valid_s1;
	req_item_t item_s1;

	// decode state
	logic [MAX_LENGTH-1:0] partial_q;
	logic [GC_W-1:0]       grp_code_q;
	logic [IW-1:0]         grp_index_q;
	logic [BT_W-1:0]       bits_taken_q;
	logic [CNT_W-1:0]      count_q [MAX_LENGTH];

	// symbol table, undefined until loaded
	logic [7:0] sym_mem [ALPHABET_SIZE];

	// output register
	logic       rsp_valid_q;
	logic       invalid_q;
	logic [7:0] sym_rd_q;

	// stage logic
	logic                  is_load_cnt;
	logic                  is_load_sym;
	logic                  is_decode;
	logic [MAX_LENGTH:0]   code_sh;
	logic [MAX_LENGTH-1:0] code;
	logic [CNT_W-1:0]      cnt;
	logic [DW-1:0]         code_dw;
	logic [DW-1:0]         first_dw;
	logic [DW-1:0]         diff;
	logic                  match;
	logic                  last_bit;
	logic [SW-1:0]         pos;
	logic                  pos_ok;
	logic                  emits;
	logic                  out_free;
	logic                  adv_s1;
	logic [FW-1:0]         fc_sum;
	logic [FW:0]           fc_next;
	logic [SW-1:0]         idx_next;
	logic [LN_W-1:0]       len_ext;
	logic [LN_W-1:0]       len_m1;
	logic                  len_ok;
	logic [SL_W-1:0]       slot_ext;
	logic                  slot_ok;
	logic [BT_W:0]         bt_ext;

	assign is_load_cnt = (item_s1.operation == OP_LOAD_COUNT);
	assign is_load_sym = (item_s1.operation == OP_LOAD_SYMBOL);
	assign is_decode   = (item_s1.operation == OP_DECODE);

	// next running code: shift in the bit, keep MAX_LENGTH bits
	assign code_sh = {partial_q, item_s1.code_bit};
	assign code    = code_sh[MAX_LENGTH-1:0];
	assign bt_ext  = {1'b0, bits_taken_q};
	assign cnt     = (bt_ext < (BT_W + 1)'(MAX_LENGTH)) ? count_q[bits_taken_q] : '0;

	// inside the current length group?
	assign code_dw  = DW'(code);
	assign first_dw = DW'(grp_code_q);
	assign diff     = code_dw - first_dw;
	assign match    = (code_dw >= first_dw) && (diff < DW'(cnt));
	assign last_bit = ((bt_ext + 1'b1) >= (BT_W + 1)'(MAX_LENGTH));

	// sorted position; diff is below cnt on a match so its low bits suffice
	assign pos    = SW'(grp_index_q) + SW'(diff[CNT_W-1:0]);
	assign pos_ok = (pos < AS_SW);

	// advance to the next length group, both values saturate
	assign fc_sum   = FW'(grp_code_q) + FW'(cnt);
	assign fc_next  = {fc_sum, 1'b0};
	assign idx_next = SW'(grp_index_q) + SW'(cnt);

	// load address checks
	assign len_ext  = LN_W'(item_s1.length_slot);
	assign len_m1   = len_ext - 1'b1;
	assign len_ok   = (len_ext != '0) && (len_ext <= ML_LN);
	assign slot_ext = SL_W'(item_s1.symbol_slot);
	assign slot_ok  = (slot_ext < SL_W'(ALPHABET_SIZE));

	// handshake: results need the output register, other items always drain
	assign emits     = is_decode && (match || last_bit);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign adv_s1    = valid_s1 && (!emits || out_free);
	assign req_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	// decode state and count table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q    <= '0;
			grp_code_q   <= '0;
			grp_index_q  <= '0;
			bits_taken_q <= '0;
			for (int i = 0; i < MAX_LENGTH; i++) begin
				count_q[i] <= '0;
			end
		end else if (adv_s1) begin
			case (item_s1.operation)
				OP_LOAD_COUNT, OP_LOAD_SYMBOL: begin
					partial_q    <= '0;
					grp_code_q   <= '0;
					grp_index_q  <= '0;
					bits_taken_q <= '0;
					if (is_load_cnt && len_ok) begin
						count_q[len_m1[BT_W-1:0]] <= item_s1.len_count;
					end
				end
				OP_DECODE: begin
					if (emits) begin
						partial_q    <= '0;
						grp_code_q   <= '0;
						grp_index_q  <= '0;
						bits_taken_q <= '0;
					end else begin
						partial_q    <= code;
						grp_code_q   <= (fc_next >= FC_CAP) ? GC_W'(FC_CAP)
						                                    : GC_W'(fc_next);
						grp_index_q  <= (idx_next >= AS_SW) ? IW'(ALPHABET_SIZE)
						                                    : IW'(idx_next);
						bits_taken_q <= bits_taken_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// symbol table write and registered read
	always_ff @(posedge clk) begin
		if (adv_s1 && is_load_sym && slot_ok) begin
			sym_mem[slot_ext[AW-1:0]] <= item_s1.symbol_value;
		end
		if (adv_s1 && emits) begin
			sym_rd_q <= sym_mem[pos[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			invalid_q   <= 1'b0;
		end else if (adv_s1 && emits) begin
			rsp_valid_q <= 1'b1;
			invalid_q   <= !(match && pos_ok);
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign rsp.invalid_code = invalid_q;
	assign rsp.symbol       = invalid_q ? 8'd0 : sym_rd_q;

	// checks
	`CHBD_ASSERT_NEXT(a_load_restarts, adv_s1 && (is_load_cnt || is_load_sym),
		(bits_taken_q == '0) && (grp_code_q == '0) && (grp_index_q == '0),
		"load did not restart decoding")
	`CHBD_ASSERT_NEXT(a_result_lands, adv_s1 && emits,
		rsp_valid,
		"completed code produced no result")
	`CHBD_ASSERT_NOW(a_no_overwrite, adv_s1 && emits,
		out_free,
		"result would overwrite a pending one")
	`CHBD_ASSERT_NOW(a_bits_bound, 1'b1,
		bt_ext < (BT_W + 1)'(MAX_LENGTH),
		"bit counter passed the maximum code length")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import chbd_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int MAX_LEN        = MAX_LENGTH_DEF;
	localparam int ALPHABET       = ALPHABET_SIZE_DEF;
	localparam int CODE_SPACE     = 1 << MAX_LEN;
	// first code of a group never goes past this
	localparam int GRP_CODE_CAP   = (1 << (MAX_LEN + 1)) - 1;
	localparam int ITEM_TARGET    = 500;
	localparam int DRAIN_CYCLES   = 8;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int PRINT_LIMIT    = 50;

	// operation 3 is unused by the block
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// what one payload bit does to the running code
	typedef enum {BIT_EXTEND, BIT_HIT, BIT_BAD} bit_outcome_t;
	// receiver behavior for one phase
	typedef enum {RX_OPEN, RX_PATTERN, RX_BURSTY} rx_mode_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;

	canonical_huffman_bit_decoder_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// decoder state as the block should hold it
	logic [8:0] count_tbl [MAX_LEN];
	logic [7:0] sym_tbl [ALPHABET];
	bit         sym_written [ALPHABET];
	int         partial_code;
	int         grp_code;
	int         grp_index;
	int         bits_taken;

	// decoded symbols and invalid-code flags still owed by the block
	rsp_item_t expected_symbols [$];

	int error_count;
	int items_sent;
	int symbols_seen;
	int invalid_seen;
	int tables_loaded;
	int cycle_count;

	// sender burst shaping
	int burst_left;
	bit sender_gaps;

	// receiver stall shaping
	rx_mode_t   rx_mode = RX_OPEN;
	logic [7:0] rx_pattern = 8'hff;
	int         stall_left = 0;

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic void restart_decode();
		partial_code = 0;
		grp_code     = 0;
		grp_index    = 0;
		bits_taken   = 0;
	endfunction

	// classify one payload bit against the current group; pos is the sorted
	// position on a hit, code and cnt feed the group advance
	function automatic bit_outcome_t classify_bit(input bit b, output int pos,
			output int code, output int cnt);
		code = ((partial_code << 1) | int'(b)) & (CODE_SPACE - 1);
		cnt  = (bits_taken < MAX_LEN) ? int'(count_tbl[bits_taken]) : 0;
		pos  = 0;
		if (code >= grp_code && code - grp_code < cnt) begin
			pos = grp_index + (code - grp_code);
			return (pos < ALPHABET) ? BIT_HIT : BIT_BAD;
		end
		return (bits_taken + 1 >= MAX_LEN) ? BIT_BAD : BIT_EXTEND;
	endfunction

	// a bit is safe unless it would read a sorted entry never loaded
	function automatic bit bit_is_safe(input bit b);
		int pos, code, cnt;
		bit_outcome_t outcome;
		outcome = classify_bit(b, pos, code, cnt);
		return !(outcome == BIT_HIT && !sym_written[pos]);
	endfunction

	// advance the tracked decoder by one accepted item
	task automatic track_decoder(input req_item_t it);
		int pos, code, cnt;
		bit_outcome_t outcome;
		rsp_item_t r;
		case (it.operation)
			OP_LOAD_COUNT: begin
				if (it.length_slot >= 1 && int'(it.length_slot) <= MAX_LEN)
					count_tbl[int'(it.length_slot) - 1] = it.len_count;
				restart_decode();
			end
			OP_LOAD_SYMBOL: begin
				if (int'(it.symbol_slot) < ALPHABET) begin
					sym_tbl[it.symbol_slot]     = it.symbol_value;
					sym_written[it.symbol_slot] = 1'b1;
				end
				restart_decode();
			end
			OP_DECODE: begin
				outcome = classify_bit(it.code_bit, pos, code, cnt);
				case (outcome)
					BIT_HIT: begin
						r.symbol       = sym_tbl[pos];
						r.invalid_code = 1'b0;
						expected_symbols.push_back(r);
						restart_decode();
					end
					BIT_BAD: begin
						r.symbol       = 8'd0;
						r.invalid_code = 1'b1;
						expected_symbols.push_back(r);
						restart_decode();
					end
					default: begin
						// move on to the next longer length group, saturating
						grp_index    = (grp_index + cnt >= ALPHABET) ?
							ALPHABET : grp_index + cnt;
						grp_code     = ((grp_code + cnt) * 2 >= GRP_CODE_CAP) ?
							GRP_CODE_CAP : (grp_code + cnt) * 2;
						partial_code = code;
						bits_taken++;
					end
				endcase
			end
			default: ;
		endcase
	endtask

	// one item through the handshake, with bursts and gaps on the sender side
	task automatic send_item(input req_item_t it);
		if (burst_left == 0) begin
			if (sender_gaps) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat ($urandom_range(0, 5)) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		track_decoder(it);
		items_sent++;
	endtask

	// unused fields carry random filler
	function automatic req_item_t random_item();
		return req_item_t'($urandom());
	endfunction

	task automatic send_count(input int len, input logic [8:0] cnt);
		req_item_t it;
		it             = random_item();
		it.operation   = OP_LOAD_COUNT;
		it.length_slot = 4'(len);
		it.len_count   = cnt;
		send_item(it);
	endtask

	task automatic send_symbol(input logic [7:0] slot, input logic [7:0] value);
		req_item_t it;
		it              = random_item();
		it.operation    = OP_LOAD_SYMBOL;
		it.symbol_slot  = slot;
		it.symbol_value = value;
		send_item(it);
	endtask

	// decode bit; flipped, or replaced by a restart, if it would read an
	// unloaded sorted entry
	task automatic send_bit(input bit b);
		req_item_t it;
		it = random_item();
		if (!bit_is_safe(b))
			b = ~b;
		if (bit_is_safe(b)) begin
			it.operation = OP_DECODE;
			it.code_bit  = b;
		end else begin
			it.operation   = OP_LOAD_COUNT;
			it.length_slot = 4'd0;
		end
		send_item(it);
	endtask

	// canonical code of sorted position k under the loaded counts
	function automatic void code_for_index(input int k, output int code, output int len);
		int first, base, cnt, bits;
		first = 0;
		base  = 0;
		code  = 0;
		len   = 0;
		for (bits = 1; bits <= MAX_LEN; bits++) begin
			cnt = count_tbl[bits - 1];
			if (len == 0 && k >= base && k < base + cnt) begin
				code = first + (k - base);
				len  = bits;
			end
			first = (first + cnt) << 1;
			base += cnt;
		end
	endfunction

	task automatic send_code(input int code, input int len);
		int i;
		for (i = len - 1; i >= 0; i--)
			send_bit(1'((code >> i) & 1));
	endtask

	// stray items between symbols: unused op, stray bit, dropped or stray loads
	task automatic send_noise();
		req_item_t it;
		int kind;
		kind = $urandom_range(0, 9);
		it   = random_item();
		case (kind)
			0, 1: begin
				it.operation = OP_UNUSED;
				send_item(it);
			end
			2, 3, 4: send_bit(1'($urandom_range(0, 1)));
			5, 6: begin
				it.operation   = OP_LOAD_COUNT;
				it.length_slot = 4'd0;
				send_item(it);
			end
			7, 8: begin
				it.operation = OP_LOAD_SYMBOL;
				send_item(it);
			end
			default: begin
				// full-range count, may break the code table until the next load
				it.operation = OP_LOAD_COUNT;
				send_item(it);
			end
		endcase
	endtask

	// random prefix-free count set, then the sorted symbols behind it
	task automatic load_code_table(input int want, output int placed);
		int avail, room, c, max_len, len, slot;
		bit descending;
		max_len = (want > 64) ? MAX_LEN : $urandom_range(1, MAX_LEN);
		avail   = 2;
		placed  = 0;
		for (len = 1; len <= MAX_LEN; len++) begin
			room = (want - placed < avail) ? want - placed : avail;
			if (len > max_len)
				c = 0;
			else if (len == max_len)
				c = room;
			else
				c = $urandom_range(0, (room == avail) ? avail - 1 : room);
			send_count(len, 9'(c));
			placed += c;
			avail   = 2 * (avail - c);
		end
		descending = 1'($urandom_range(0, 1));
		for (slot = 0; slot < placed; slot++)
			send_symbol(8'(descending ? placed - 1 - slot : slot), 8'($urandom()));
		tables_loaded++;
	endtask

	task automatic set_idling();
		sender_gaps = $urandom_range(0, 2) != 0;
		rx_mode     = rx_mode_t'($urandom_range(0, 2));
		rx_pattern  = 8'($urandom()) | 8'h01;
	endtask

	// counts are clear after reset: every bit string runs out at max length
	task automatic test_empty_table();
		repeat (MAX_LEN) send_bit(1'($urandom_range(0, 1)));
	endtask

	task automatic test_edge_cases();
		int i;
		// length slot 0 stores nothing but still restarts
		send_count(0, 9'h1ff);
		// one code of length 1, then all 256 codes of length 9
		send_count(1, 9'd1);
		send_count(9, 9'd256);
		send_symbol(8'd0, 8'ha5);
		send_bit(1'b0);
		send_item('{operation: OP_UNUSED, code_bit: 1'b1, length_slot: 4'hf,
			len_count: 9'h1ff, symbol_slot: 8'hff, symbol_value: 8'hff});
		// last length 9 code lands one past the sorted table
		for (i = 0; i < 9; i++)
			send_bit(1'b1);
	endtask

	task automatic test_random_streams();
		int rounds, want, placed, k, code, len, cut;
		rounds = 0;
		while (items_sent < ITEM_TARGET) begin
			set_idling();
			want = (rounds == 0) ? $urandom_range(130, ALPHABET) : $urandom_range(1, 24);
			load_code_table(want, placed);
			repeat ($urandom_range(10, 30)) begin
				if ($urandom_range(0, 9) == 0) begin
					send_noise();
				end else if (placed == 0) begin
					send_bit(1'($urandom_range(0, 1)));
				end else begin
					k = $urandom_range(0, placed - 1);
					code_for_index(k, code, len);
					if (len != 0 && len > 1 && $urandom_range(0, 11) == 0) begin
						// broken code: a prefix, then something else
						cut = $urandom_range(1, len - 1);
						send_code(code >> (len - cut), cut);
						send_noise();
					end else if (len != 0) begin
						send_code(code, len);
					end
				end
			end
			rounds++;
		end
	endtask

	// receiver: open, a rotating ready pattern, or random long stalls
	always @(negedge clk) begin
		if (stall_left != 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else begin
			case (rx_mode)
				RX_PATTERN: begin
					rsp_ready  <= rx_pattern[0];
					rx_pattern  = {rx_pattern[0], rx_pattern[7:1]};
				end
				RX_BURSTY: begin
					rsp_ready <= 1'b1;
					if ($urandom_range(0, 3) == 0)
						stall_left = $urandom_range(1, 10);
				end
				default: rsp_ready <= 1'b1;
			endcase
		end
	end

	// compare each result item with the oldest expectation
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (rsp.invalid_code)
				invalid_seen++;
			else
				symbols_seen++;
			if (expected_symbols.size() == 0) begin
				report_mismatch($sformatf("unexpected item symbol=%02h invalid=%0b",
					rsp.symbol, rsp.invalid_code));
			end else begin
				want = expected_symbols.pop_front();
				if (rsp.symbol !== want.symbol)
					report_mismatch($sformatf("symbol %02h, expected %02h",
						rsp.symbol, want.symbol));
				if (rsp.invalid_code !== want.invalid_code)
					report_mismatch($sformatf("invalid_code %0b, expected %0b",
						rsp.invalid_code, want.invalid_code));
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d items outstanding",
			cycle_count, expected_symbols.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int i;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		error_count   = 0;
		items_sent    = 0;
		symbols_seen  = 0;
		invalid_seen  = 0;
		tables_loaded = 0;
		burst_left    = 0;
		sender_gaps   = 1'b0;
		for (i = 0; i < MAX_LEN; i++)
			count_tbl[i] = '0;
		for (i = 0; i < ALPHABET; i++) begin
			sym_tbl[i]     = '0;
			sym_written[i] = 1'b0;
		end
		restart_decode();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_edge_cases();
		test_random_streams();

		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_symbols.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d items over %0d code tables; received %0d symbols, %0d invalid codes",
			items_sent, tables_loaded, symbols_seen, invalid_seen);
		$display("%0d mismatches in %0d cycles", error_count, cycle_count);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/chbd_pkg.sv
src/canonical_huffman_bit_decoder_unit.sv
sim/testbench.sv
